// ===== rtl/de_rham_curve_point_defines.svh =====
// assertion macros shared by the curve point rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef DE_RHAM_CURVE_POINT_DEFINES_SVH
`define DE_RHAM_CURVE_POINT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DRCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DRCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drcp_pkg.sv =====
// types, constants and the fixed point multiply for the curve point block
// no dependencies
`default_nettype none

package drcp_pkg;

    localparam int DATA_W    = 32;
    localparam int PARAM_W   = 30;
    localparam int FRAC_BITS = 28;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] Q_ONE  = 32'h1000_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0800_0000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_E  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_F  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_G  = 3'd5;

    // register reset values
    localparam logic [DATA_W-1:0] RST_AX = 32'd134217728;
    localparam logic [DATA_W-1:0] RST_AY = 32'd77491858;

    // affine coefficients broadcast to every cell
    typedef struct packed {
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] f;
        logic signed [DATA_W-1:0] g;
        logic signed [DATA_W-1:0] omax;
    } coef_t;

    // point in flight plus the map select bits still to be used
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [PARAM_W-1:0]       bits;
    } point_t;

    // q4.28 product, floor shift, low 32 bits kept
    function automatic logic signed [DATA_W-1:0] qmul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [2*DATA_W-1:0] p;
        begin
            p = a * b;
            return p[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/drcp_cell.sv =====
// one step of the curve iteration: a multiply stage and an add stage
// depends on drcp_pkg and de_rham_curve_point_defines.svh
`default_nettype none

`include "de_rham_curve_point_defines.svh"

module drcp_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire drcp_pkg::coef_t coef,
    input  wire logic            up_valid,
    input  wire drcp_pkg::point_t up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output drcp_pkg::point_t     dn_data,
    input  wire logic            dn_ready
);

    // multiply stage registers
    logic                                 a_valid_reg, a_valid_next;
    logic                                 a_sel_reg;
    logic signed [drcp_pkg::DATA_W-1:0]   px_reg, qx_reg, py_reg, qy_reg;
    logic [drcp_pkg::PARAM_W-1:0]         a_bits_reg;

    // add stage registers
    logic                                 b_valid_reg, b_valid_next;
    drcp_pkg::point_t                     b_data_reg;

    logic                                 a_ready;
    logic                                 b_ready;
    logic                                 sel;
    logic signed [drcp_pkg::DATA_W-1:0]   cx, cy, cey;
    logic signed [drcp_pkg::DATA_W-1:0]   base;
    drcp_pkg::point_t                     b_data_next;

    // stage moves when empty or when its successor takes the transaction
    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    // coefficient select for this step's map
    assign sel = up_data.bits[0];
    assign cx  = sel ? coef.omax : coef.ax;
    assign cy  = sel ? coef.f    : coef.d;
    assign cey = sel ? coef.g    : coef.e;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_ready)
        begin
            a_valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // products of the old point, registered
    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_sel_reg  <= sel;
            px_reg     <= drcp_pkg::qmul(cx, up_data.x);
            qx_reg     <= drcp_pkg::qmul(cy, up_data.y);
            py_reg     <= drcp_pkg::qmul(coef.ay, up_data.x);
            qy_reg     <= drcp_pkg::qmul(cey, up_data.y);
            a_bits_reg <= {1'b0, up_data.bits[drcp_pkg::PARAM_W-1:1]};
        end
    end

    // sums forming the new point
    assign base = a_sel_reg ? coef.ax : '0;

    always_comb
    begin
        b_data_next.x    = base + px_reg + qx_reg;
        b_data_next.y    = a_sel_reg ? (coef.ay - py_reg + qy_reg) : (py_reg + qy_reg);
        b_data_next.bits = a_bits_reg;
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_ready)
        begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_data  = b_data_reg;

    // checks
    `DRCP_ASSERT_NOW(a_empty_takes, !a_valid_reg, up_ready, "empty multiply stage refused input")
    `DRCP_ASSERT_NEXT(a_held, a_valid_reg && !b_ready,
        a_valid_reg && $stable(px_reg) && $stable(qy_reg), "multiply stage lost held products")
    `DRCP_ASSERT_NEXT(a_to_b, a_valid_reg && b_ready, b_valid_reg,
        "add stage did not capture transaction")
    `DRCP_ASSERT_NEXT(b_held, b_valid_reg && !dn_ready,
        b_valid_reg && $stable(b_data_reg), "add stage dropped a stalled point")

endmodule

`default_nettype wire

// ===== rtl/de_rham_curve_point.sv =====
// Curve point evaluator: one parameter fraction in, one q4.28 point out per transaction.
// The core is a chain of STEP_COUNT cells, each applying one affine map step in two
// pipeline stages (four 32x32 multiplies, then the sums), so a result passes a multiply
// register and an add register in every cell before it is offered, and a new fraction
// is accepted every cycle while out_stall is low. Stalls collapse bubbles stage by
// stage; the last stage is the output register. The user must write coefficients through
// the configuration port only while the block is idle; the block does not enforce it.
// depends on drcp_pkg and drcp_cell
`default_nettype none

module de_rham_curve_point
#(
    parameter int STEP_COUNT = 30
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [drcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [drcp_pkg::DATA_W-1:0]          cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [drcp_pkg::PARAM_W-1:0]         param_fraction,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [drcp_pkg::DATA_W-1:0]        point_x,
    output logic signed [drcp_pkg::DATA_W-1:0]        point_y
);

    logic signed [drcp_pkg::DATA_W-1:0] ax_reg, ay_reg, d_reg, e_reg, f_reg, g_reg;
    drcp_pkg::coef_t                    coef;

    logic             valid_w [STEP_COUNT+1];
    logic             ready_w [STEP_COUNT+1];
    drcp_pkg::point_t data_w  [STEP_COUNT+1];

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= drcp_pkg::RST_AX;
            ay_reg <= drcp_pkg::RST_AY;
            d_reg  <= '0;
            e_reg  <= '0;
            f_reg  <= '0;
            g_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                drcp_pkg::REG_AX: ax_reg <= cfg_wdata;
                drcp_pkg::REG_AY: ay_reg <= cfg_wdata;
                drcp_pkg::REG_D:  d_reg  <= cfg_wdata;
                drcp_pkg::REG_E:  e_reg  <= cfg_wdata;
                drcp_pkg::REG_F:  f_reg  <= cfg_wdata;
                drcp_pkg::REG_G:  g_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        coef.ax   = ax_reg;
        coef.ay   = ay_reg;
        coef.d    = d_reg;
        coef.e    = e_reg;
        coef.f    = f_reg;
        coef.g    = g_reg;
        coef.omax = drcp_pkg::Q_ONE - ax_reg;
    end

    // chain entry: start point (0.5, 0)
    assign valid_w[0]     = in_valid;
    assign data_w[0].x    = drcp_pkg::Q_HALF;
    assign data_w[0].y    = '0;
    assign data_w[0].bits = param_fraction;
    assign in_stall       = !ready_w[0];

    // one cell per step
    for (genvar k = 0; k < STEP_COUNT; k++)
    begin : g_cell
        drcp_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .coef     (coef),
            .up_valid (valid_w[k]),
            .up_data  (data_w[k]),
            .up_ready (ready_w[k]),
            .dn_valid (valid_w[k+1]),
            .dn_data  (data_w[k+1]),
            .dn_ready (ready_w[k+1])
        );
    end

    // chain exit
    assign ready_w[STEP_COUNT] = !out_stall;
    assign out_valid           = valid_w[STEP_COUNT];
    assign point_x             = data_w[STEP_COUNT].x;
    assign point_y             = data_w[STEP_COUNT].y;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for de_rham_curve_point: random and directed fractions
// under several coefficient settings, with an in-bench fixed point predictor
// depends on drcp_pkg and the de_rham_curve_point rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CURVE_STEPS    = 30;
    localparam int PIPE_LATENCY   = 2 * CURVE_STEPS;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // indexes past the last coefficient, writes there must be ignored
    localparam logic [drcp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [drcp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [drcp_pkg::DATA_W-1:0] x;
        logic [drcp_pkg::DATA_W-1:0] y;
    } curve_point_t;

    typedef struct packed {
        logic [drcp_pkg::DATA_W-1:0] ax;
        logic [drcp_pkg::DATA_W-1:0] ay;
        logic [drcp_pkg::DATA_W-1:0] d;
        logic [drcp_pkg::DATA_W-1:0] e;
        logic [drcp_pkg::DATA_W-1:0] f;
        logic [drcp_pkg::DATA_W-1:0] g;
    } coef_set_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [drcp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [drcp_pkg::DATA_W-1:0]        cfg_wdata = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [drcp_pkg::PARAM_W-1:0]       param_fraction = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [drcp_pkg::DATA_W-1:0] point_x;
    logic signed [drcp_pkg::DATA_W-1:0] point_y;

    // fractions waiting to be sent and points waiting to come back
    logic [drcp_pkg::PARAM_W-1:0] fraction_queue[$];
    curve_point_t                 expected_points[$];
    coef_set_t                    coef_copy;

    int  error_count = 0;
    int  fractions_sent = 0;
    int  points_checked = 0;
    int  settings_used = 0;
    int  idle_cycles = 0;
    bit  gaps_enabled = 1'b1;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  tx_gap_left = 0;
    int  tx_quiet_left = 0;
    int  rx_stall_left = 0;
    int  rx_quiet_left = 0;
    int unsigned  tx_roll;
    int unsigned  rx_roll;
    curve_point_t want_point;

    de_rham_curve_point #(.STEP_COUNT(CURVE_STEPS)) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .param_fraction (param_fraction),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .point_x        (point_x),
        .point_y        (point_y)
    );

    always #5 clk = ~clk;

    // q4.28 product: exact 64-bit result, floor shift by 28, low word kept
    function automatic logic [drcp_pkg::DATA_W-1:0] fixed_mul(
        input logic [drcp_pkg::DATA_W-1:0] a,
        input logic [drcp_pkg::DATA_W-1:0] b
    );
        logic signed [2*drcp_pkg::DATA_W-1:0] wide;
        wide = $signed({{drcp_pkg::DATA_W{a[drcp_pkg::DATA_W-1]}}, a})
             * $signed({{drcp_pkg::DATA_W{b[drcp_pkg::DATA_W-1]}}, b});
        return wide[drcp_pkg::FRAC_BITS+drcp_pkg::DATA_W-1:drcp_pkg::FRAC_BITS];
    endfunction

    // walk the fraction bits lsb first, map 1 on a set bit, map 0 otherwise
    function automatic curve_point_t curve_point_of(
        input logic [drcp_pkg::PARAM_W-1:0] fraction,
        input coef_set_t c
    );
        logic [drcp_pkg::DATA_W-1:0] x;
        logic [drcp_pkg::DATA_W-1:0] y;
        logic [drcp_pkg::DATA_W-1:0] nx;
        logic [drcp_pkg::DATA_W-1:0] ny;
        logic [drcp_pkg::DATA_W-1:0] one_minus_ax;
        logic                        map_one;
        curve_point_t                pt;
        x = drcp_pkg::Q_HALF;
        y = '0;
        one_minus_ax = drcp_pkg::Q_ONE - c.ax;
        for (int i = 0; i < CURVE_STEPS; i++)
        begin
            map_one = (i < drcp_pkg::PARAM_W) ? fraction[i] : 1'b0;
            if (map_one)
            begin
                nx = c.ax + fixed_mul(one_minus_ax, x) + fixed_mul(c.f, y);
                ny = c.ay - fixed_mul(c.ay, x) + fixed_mul(c.g, y);
            end
            else
            begin
                nx = fixed_mul(c.ax, x) + fixed_mul(c.d, y);
                ny = fixed_mul(c.ay, x) + fixed_mul(c.e, y);
            end
            x = nx;
            y = ny;
        end
        pt.x = x;
        pt.y = y;
        return pt;
    endfunction

    // idle stretch length: mostly short, now and then long
    function automatic int idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random fraction: full random, sparse bits or dense bits
    function automatic logic [drcp_pkg::PARAM_W-1:0] random_fraction();
        int unsigned                  roll;
        logic [drcp_pkg::PARAM_W-1:0] v;
        roll = $urandom_range(0, 99);
        v = drcp_pkg::PARAM_W'($urandom());
        if (roll < 15)
            v = (drcp_pkg::PARAM_W'(1) << $urandom_range(0, drcp_pkg::PARAM_W-1))
                | (drcp_pkg::PARAM_W'($urandom_range(0, 1))
                   << $urandom_range(0, drcp_pkg::PARAM_W-1));
        else if (roll < 30)
            v = ~((drcp_pkg::PARAM_W'(1) << $urandom_range(0, drcp_pkg::PARAM_W-1))
                  | (drcp_pkg::PARAM_W'($urandom_range(0, 1))
                     << $urandom_range(0, drcp_pkg::PARAM_W-1)));
        return v;
    endfunction

    // signed value spread evenly over -span..span
    function automatic logic [drcp_pkg::DATA_W-1:0] spread_signed(input int unsigned span);
        return drcp_pkg::DATA_W'($urandom_range(0, 2 * span)) - drcp_pkg::DATA_W'(span);
    endfunction

    // sender: one transaction per accepted fraction, gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            param_fraction <= '0;
            tx_gap_left    <= 0;
            tx_quiet_left  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_points.push_back(curve_point_of(param_fraction, coef_copy));
                fractions_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap_left != 0)
                begin
                    tx_gap_left <= tx_gap_left - 1;
                    in_valid    <= 1'b0;
                end
                else if (fraction_queue.size() != 0)
                begin
                    in_valid       <= 1'b1;
                    param_fraction <= fraction_queue.pop_front();
                    tx_roll = $urandom_range(0, 99);
                    if (!gaps_enabled)
                        tx_gap_left <= 0;
                    else if (tx_quiet_left != 0)
                        tx_quiet_left <= tx_quiet_left - 1;
                    else if (tx_roll < 3)
                        tx_quiet_left <= $urandom_range(20, 80);
                    else if (tx_roll < 35)
                        tx_gap_left <= idle_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each point transaction and drive random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            hold_left     <= 0;
            rx_stall_left <= 0;
            rx_quiet_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("point with nothing expected: x %h y %h", point_x, point_y);
                    error_count++;
                end
                else
                begin
                    want_point = expected_points.pop_front();
                    if (point_x !== want_point.x)
                    begin
                        $error("point_x: expected %h, got %h", want_point.x, point_x);
                        error_count++;
                    end
                    if (point_y !== want_point.y)
                    begin
                        $error("point_y: expected %h, got %h", want_point.y, point_y);
                        error_count++;
                    end
                    points_checked++;
                end
            end

            // long hold-off on request, then short random stalls
            if (hold_served != hold_asked)
            begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES - 1;
                out_stall   <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (rx_stall_left != 0)
            begin
                rx_stall_left <= rx_stall_left - 1;
                out_stall     <= 1'b1;
            end
            else if (rx_quiet_left != 0)
            begin
                rx_quiet_left <= rx_quiet_left - 1;
                out_stall     <= 1'b0;
            end
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 3)
                begin
                    rx_quiet_left <= $urandom_range(30, 120);
                    out_stall     <= 1'b0;
                end
                else if (rx_roll < 30)
                begin
                    rx_stall_left <= idle_length() - 1;
                    out_stall     <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // one register write, the enable stays up across back-to-back writes
    task automatic write_coef(input logic [drcp_pkg::CFG_IDX_W-1:0] idx,
                              input logic [drcp_pkg::DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            drcp_pkg::REG_AX: coef_copy.ax = value;
            drcp_pkg::REG_AY: coef_copy.ay = value;
            drcp_pkg::REG_D:  coef_copy.d  = value;
            drcp_pkg::REG_E:  coef_copy.e  = value;
            drcp_pkg::REG_F:  coef_copy.f  = value;
            drcp_pkg::REG_G:  coef_copy.g  = value;
            default: ;
        endcase
    endtask

    task automatic write_all_coefs(input coef_set_t c);
        write_coef(drcp_pkg::REG_AX, c.ax);
        write_coef(drcp_pkg::REG_AY, c.ay);
        write_coef(drcp_pkg::REG_D, c.d);
        write_coef(drcp_pkg::REG_E, c.e);
        write_coef(drcp_pkg::REG_F, c.f);
        write_coef(drcp_pkg::REG_G, c.g);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // field extremes and bit patterns
    task automatic queue_directed();
        fraction_queue.push_back('0);
        fraction_queue.push_back('1);
        fraction_queue.push_back(drcp_pkg::PARAM_W'(1));
        fraction_queue.push_back(drcp_pkg::PARAM_W'(1) << (drcp_pkg::PARAM_W-1));
        fraction_queue.push_back(30'h2AAA_AAAA);
        fraction_queue.push_back(30'h1555_5555);
        fraction_queue.push_back(30'h2000_0001);
        fraction_queue.push_back(30'h1FFF_FFFE);
        fraction_queue.push_back(30'h0000_7FFF);
        fraction_queue.push_back(30'h3FFF_8000);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            fraction_queue.push_back(random_fraction());
    endtask

    // wait until the sender is empty and every point has come back
    task automatic drain();
        while (fraction_queue.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        coef_set_t c;
        coef_copy = '{ax: drcp_pkg::RST_AX, ay: drcp_pkg::RST_AY, d: '0, e: '0, f: '0,
                      g: '0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients, directed fractions, then a long output hold-off
        settings_used++;
        queue_directed();
        drain();
        gaps_enabled = 1'b0;
        hold_asked++;
        queue_random(150);
        drain();
        gaps_enabled = 1'b1;

        // most negative coefficients
        c = '{ax: 32'h8000_0000, ay: 32'h8000_0000, d: 32'h8000_0000,
              e: 32'h8000_0000, f: 32'h8000_0000, g: 32'h8000_0000};
        write_all_coefs(c);
        queue_random(40);
        drain();

        // most positive coefficients
        c = '{ax: 32'h7FFF_FFFF, ay: 32'h7FFF_FFFF, d: 32'h7FFF_FFFF,
              e: 32'h7FFF_FFFF, f: 32'h7FFF_FFFF, g: 32'h7FFF_FFFF};
        write_all_coefs(c);
        queue_directed();
        queue_random(40);
        drain();

        // all zero
        write_all_coefs('0);
        queue_random(30);
        drain();

        // contracting maps with small cross terms
        c.ax = $urandom_range(0, drcp_pkg::Q_ONE);
        c.ay = spread_signed(32'h0C00_0000);
        c.d  = spread_signed(32'h0400_0000);
        c.e  = spread_signed(32'h0400_0000);
        c.f  = spread_signed(32'h0400_0000);
        c.g  = spread_signed(32'h0400_0000);
        write_all_coefs(c);
        queue_random(80);
        drain();
        c.e = spread_signed(32'h0800_0000);
        c.g = spread_signed(32'h0800_0000);
        write_all_coefs(c);
        queue_random(80);
        drain();

        // full range coefficients, plus writes to the unused indexes
        c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        write_all_coefs(c);
        write_coef(REG_SPARE_LO, $urandom());
        write_coef(REG_SPARE_HI, $urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(140);
        drain();

        // back to the classic curve
        c = '{ax: drcp_pkg::RST_AX, ay: drcp_pkg::RST_AY, d: '0, e: '0, f: '0, g: '0};
        write_all_coefs(c);
        queue_random(80);
        drain();

        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (expected_points.size() != 0)
        begin
            $error("%0d points never arrived", expected_points.size());
            error_count++;
        end
        $display("sent %0d fractions under %0d coefficient settings", fractions_sent,
                 settings_used);
        $display("checked %0d points, including a %0d-cycle output hold-off", points_checked,
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
